// ----- sv/accel_tilt_angle_macros.svh -----
// Assertion macros for the tilt angle block.
`ifndef ACCEL_TILT_ANGLE_MACROS_SVH
`define ACCEL_TILT_ANGLE_MACROS_SVH

// Consequent must hold on the following clock edge.
`define ATA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tilt angle assertion failed");

// Consequent must hold on the same clock edge.
`define ATA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tilt angle assertion failed");

`endif

// ----- sv/ata_pkg.sv -----
// Shared types, constants and the arctangent table for the tilt angle block.
package ata_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int CORDIC_STEPS_DEF    = 16;
  localparam int TABLE_LEN           = 24;
  localparam int STEP_W              = 5;
  localparam int GUARD_BITS          = 12;
  localparam int VEC_W               = 34;
  localparam int ANG_W               = 27;
  localparam int AXIS_W              = 17;
  localparam int PADDR_W             = 4;

  localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MAG,
    OP_MUL,
    OP_AINIT,
    OP_ANG,
    OP_ROUND
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [STEP_W-1:0] step;
  } cmd_t;

  typedef struct packed {
    logic start;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [7:0] x_low;
    logic [7:0] x_high;
    logic [7:0] y_low;
    logic [7:0] y_high;
    logic [7:0] z_low;
    logic [7:0] z_high;
  } in_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic [31:0]        reading_count;
  } out_t;

  // atan(2^-i) in degrees * 2^16
  function automatic logic [21:0] atan_entry(input logic [STEP_W-1:0] i);
    logic [21:0] v;
    case (i)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/accel_tilt_angle.sv -----
// Tilt angle block top level: offset registers, sequencer, datapath, result register.
// Usage:
//  Input channel (in_valid_i / in_stall_o) takes one word: six little-endian sample
//  bytes. Output channel (out_valid_o / out_stall_i) gives roll, pitch and the
//  wrapping reading count. A word moves when valid is high and stall is low.
//  Offsets are written over the APB port (offset_x at 0x0, _y at 0x4, _z at 0x8).
//  Each word runs load, N magnitude iterations, gain removal, arctangent setup,
//  N arctangent iterations and rounding, N = CORDIC_STEPS (capped at 24, default 16).
//  Both CORDIC passes (magnitude then arctangent) run one iteration a cycle on a
//  two-lane datapath; a new word is taken only once the last one has gone to
//  the output register.
//  in_stall_o is high while a word is being worked on.
//  A finished result sits in the output register; while the receiver stalls it
//  holds, and the next input word is still taken and worked on, waiting at the
//  end for the register to free.
//  Reset clears the offsets, the reading count and all valid state.
`include "accel_tilt_angle_macros.svh"

module accel_tilt_angle #(
  parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int CORDIC_STEPS    = ata_pkg::CORDIC_STEPS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  ata_pkg::in_t                in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output ata_pkg::out_t               out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ata_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic signed [15:0] off_q [3];
  logic [31:0]        cnt_q;
  logic               out_valid_q;
  ata_pkg::out_t      out_q;
  ata_pkg::stat_t     stat;
  ata_pkg::cmd_t      cmd;
  logic               busy, out_load, in_acc, wr;
  logic signed [15:0] roll, pitch;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      ata_pkg::REG_OFFSET_X: prdata = {16'd0, off_q[0]};
      ata_pkg::REG_OFFSET_Y: prdata = {16'd0, off_q[1]};
      ata_pkg::REG_OFFSET_Z: prdata = {16'd0, off_q[2]};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (wr) begin
      case (paddr[3:2])
        ata_pkg::REG_OFFSET_X: off_q[0] <= pwdata[15:0];
        ata_pkg::REG_OFFSET_Y: off_q[1] <= pwdata[15:0];
        ata_pkg::REG_OFFSET_Z: off_q[2] <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign stat.start    = in_acc;
  assign stat.out_free = !out_valid_q || !out_stall_i;

  ata_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .out_load_o(out_load)
  );

  ata_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk_i,
    .cmd_i    (cmd),
    .in_data_i,
    .off_x_i  (off_q[0]),
    .off_y_i  (off_q[1]),
    .off_z_i  (off_q[2]),
    .roll_o   (roll),
    .pitch_o  (pitch)
  );

  assign in_stall_o = busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) cnt_q <= cnt_q + 32'd1;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.roll_angle    <= roll;
      out_q.pitch_angle   <= pitch;
      out_q.reading_count <= cnt_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ATA_ASSERT_NEXT(a_busy_after_accept, in_acc, in_stall_o)
  `ATA_ASSERT_NOW(a_count_matches, $rose(out_valid_o), out_data_o.reading_count == cnt_q)
  `ATA_ASSERT_NEXT(a_stalled_word_held, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

endmodule

// ----- sv/ata_ctrl.sv -----
// Sequencer for the tilt angle datapath.
module ata_ctrl #(
  parameter int CORDIC_STEPS = ata_pkg::CORDIC_STEPS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ata_pkg::stat_t stat_i,
  output ata_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           out_load_o
);

  localparam int N = (CORDIC_STEPS > ata_pkg::TABLE_LEN) ? ata_pkg::TABLE_LEN : CORDIC_STEPS;
  localparam logic [ata_pkg::STEP_W-1:0] LAST = ata_pkg::STEP_W'(N - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAG   = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_AINIT = 3'd3;
  localparam logic [2:0] S_ANG   = 3'd4;
  localparam logic [2:0] S_ROUND = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [ata_pkg::STEP_W-1:0]  cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = ata_pkg::OP_NONE;
    cmd_o.step = cnt_q;
    out_load_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.start) begin
          cmd_o.op = ata_pkg::OP_LOAD;
          cnt_d    = '0;
          state_d  = S_MAG;
        end
      end
      S_MAG: begin
        cmd_o.op = ata_pkg::OP_MAG;
        if (cnt_q == LAST) begin
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.op = ata_pkg::OP_MUL;
        state_d  = S_AINIT;
      end
      S_AINIT: begin
        cmd_o.op = ata_pkg::OP_AINIT;
        cnt_d    = '0;
        state_d  = S_ANG;
      end
      S_ANG: begin
        cmd_o.op = ata_pkg::OP_ANG;
        if (cnt_q == LAST) begin
          state_d = S_ROUND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ROUND: begin
        cmd_o.op = ata_pkg::OP_ROUND;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          out_load_o = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ----- sv/ata_dp.sv -----
// Two-lane CORDIC datapath: magnitude, gain removal, arctangent, rounding.
module ata_dp #(
  parameter int ANGLE_FRAC_BITS = ata_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  ata_pkg::cmd_t      cmd_i,
  input  ata_pkg::in_t       in_data_i,
  input  logic signed [15:0] off_x_i,
  input  logic signed [15:0] off_y_i,
  input  logic signed [15:0] off_z_i,
  output logic signed [15:0] roll_o,
  output logic signed [15:0] pitch_o
);

  localparam int VW = ata_pkg::VEC_W;
  localparam int AW = ata_pkg::ANG_W;
  localparam int AX = ata_pkg::AXIS_W;
  localparam int SH = 16 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] RND  = AW'(1) <<< (15 - ANGLE_FRAC_BITS);
  localparam logic signed [AW-1:0] FULL = AW'(90) <<< ANGLE_FRAC_BITS;

  // lane 0 gives roll, lane 1 gives pitch
  logic signed [VW-1:0] p_q [2], p_d [2];
  logic signed [VW-1:0] q_q [2], q_d [2];
  logic signed [AW-1:0] ang_q [2], ang_d [2];
  logic signed [AX-1:0] num_q [2], num_d [2];
  logic [59:0]          prod_q [2], prod_d [2];
  logic                 nz_q [2], nz_d [2];
  logic                 dz_q [2], dz_d [2];
  logic signed [15:0]   res_q [2], res_d [2];

  logic signed [AX-1:0] cx, cy, cz;
  logic signed [AX-1:0] va [2], vb [2];
  logic [AX-1:0]        aa [2], ab [2];
  logic signed [VW-1:0] dp [2], dq [2];
  logic [29:0]          mag [2];
  logic signed [AW-1:0] r [2], rr [2];
  logic signed [AW-1:0] tab;

  function automatic logic signed [15:0] sat16(input logic signed [AW-1:0] v);
    logic signed [15:0] o;
    if (v > AW'(32767)) o = 16'sh7fff;
    else if (v < -AW'(32768)) o = 16'sh8000;
    else o = v[15:0];
    return o;
  endfunction

  assign cx = AX'($signed({in_data_i.x_high, in_data_i.x_low})) - AX'(off_x_i);
  assign cy = AX'($signed({in_data_i.y_high, in_data_i.y_low})) - AX'(off_y_i);
  assign cz = AX'($signed({in_data_i.z_high, in_data_i.z_low})) - AX'(off_z_i);

  assign va[0] = cx;
  assign vb[0] = cz;
  assign va[1] = cy;
  assign vb[1] = cz;

  assign tab = $signed({{(AW-22){1'b0}}, ata_pkg::atan_entry(cmd_i.step)});

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      p_d[l]    = p_q[l];
      q_d[l]    = q_q[l];
      ang_d[l]  = ang_q[l];
      num_d[l]  = num_q[l];
      prod_d[l] = prod_q[l];
      nz_d[l]   = nz_q[l];
      dz_d[l]   = dz_q[l];
      res_d[l]  = res_q[l];
      aa[l]     = va[l][AX-1] ? AX'(-va[l]) : AX'(va[l]);
      ab[l]     = vb[l][AX-1] ? AX'(-vb[l]) : AX'(vb[l]);
      dp[l]     = q_q[l] >>> cmd_i.step;
      dq[l]     = p_q[l] >>> cmd_i.step;
      mag[l]    = prod_q[l][59:30];
      r[l]      = (ang_q[l] + RND) >>> SH;
      if (r[l] > FULL) r[l] = FULL;
      if (r[l] < -FULL) r[l] = -FULL;
      if (!nz_q[l]) rr[l] = '0;
      else if (dz_q[l]) rr[l] = num_q[l][AX-1] ? -FULL : FULL;
      else rr[l] = r[l];
      case (cmd_i.op)
        ata_pkg::OP_LOAD: begin
          p_d[l] = $signed({{(VW-AX-ata_pkg::GUARD_BITS){1'b0}}, aa[l],
                            {ata_pkg::GUARD_BITS{1'b0}}});
          q_d[l] = $signed({{(VW-AX-ata_pkg::GUARD_BITS){1'b0}}, ab[l],
                            {ata_pkg::GUARD_BITS{1'b0}}});
          num_d[l] = (l == 0) ? cy : cx;
        end
        ata_pkg::OP_MAG: begin
          if (q_q[l] > 0) begin
            p_d[l] = p_q[l] + dp[l];
            q_d[l] = q_q[l] - dq[l];
          end else begin
            p_d[l] = p_q[l] - dp[l];
            q_d[l] = q_q[l] + dq[l];
          end
        end
        ata_pkg::OP_MUL: begin
          prod_d[l] = p_q[l][29:0] * ata_pkg::INV_GAIN_Q30;
        end
        ata_pkg::OP_AINIT: begin
          p_d[l]   = $signed({{(VW-30){1'b0}}, mag[l]});
          q_d[l]   = VW'(num_q[l]) <<< ata_pkg::GUARD_BITS;
          ang_d[l] = '0;
          nz_d[l]  = (num_q[l] != '0);
          dz_d[l]  = (mag[l] == '0);
        end
        ata_pkg::OP_ANG: begin
          if (q_q[l] >= 0) begin
            p_d[l]   = p_q[l] + dp[l];
            q_d[l]   = q_q[l] - dq[l];
            ang_d[l] = ang_q[l] + tab;
          end else begin
            p_d[l]   = p_q[l] - dp[l];
            q_d[l]   = q_q[l] + dq[l];
            ang_d[l] = ang_q[l] - tab;
          end
        end
        ata_pkg::OP_ROUND: begin
          res_d[l] = sat16((l == 0) ? -rr[l] : rr[l]);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 2; l++) begin
      p_q[l]    <= p_d[l];
      q_q[l]    <= q_d[l];
      ang_q[l]  <= ang_d[l];
      num_q[l]  <= num_d[l];
      prod_q[l] <= prod_d[l];
      nz_q[l]   <= nz_d[l];
      dz_q[l]   <= dz_d[l];
      res_q[l]  <= res_d[l];
    end
  end

  assign roll_o  = res_q[0];
  assign pitch_o = res_q[1];

endmodule

// ----- tb/tb.sv -----
// Testbench for the accelerometer tilt angle block: self-checking, random stalls.
module tb;

  localparam int FRAC = ata_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int STEPS = ata_pkg::CORDIC_STEPS_DEF;
  localparam int LAT = 2 * STEPS + 4;
  localparam int WDOG_LIMIT = 20000;
  localparam longint INV_GAIN = 652032874;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_stall_o;
  ata_pkg::in_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  ata_pkg::out_t out_data_o;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [ata_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  accel_tilt_angle DUT (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  logic signed [15:0] off_x, off_y, off_z;
  logic [31:0] readings;
  ata_pkg::out_t angles_due[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_recv = 1'b0;
  int idle_cycles = 0;

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint vec_magnitude(longint a, longint b);
    longint p, q, dp, dq;
    int n;
    p = (a < 0 ? -a : a) <<< ata_pkg::GUARD_BITS;
    q = (b < 0 ? -b : b) <<< ata_pkg::GUARD_BITS;
    n = STEPS > ata_pkg::TABLE_LEN ? ata_pkg::TABLE_LEN : STEPS;
    for (int i = 0; i < n; i++) begin
      dp = floor_shift(q, i);
      dq = floor_shift(p, i);
      if (q > 0) begin
        p += dp; q -= dq;
      end else begin
        p -= dp; q += dq;
      end
    end
    return (p * INV_GAIN) >>> 30;
  endfunction

  function automatic longint tilt_deg(longint num, longint den);
    longint full, ang, p, q, dp, dq, r;
    int n;
    full = longint'(90) <<< FRAC;
    ang = 0;
    if (num == 0) return 0;
    if (den <= 0) return num > 0 ? full : -full;
    p = den;
    q = num <<< ata_pkg::GUARD_BITS;
    n = STEPS > ata_pkg::TABLE_LEN ? ata_pkg::TABLE_LEN : STEPS;
    for (int i = 0; i < n; i++) begin
      dp = floor_shift(q, i);
      dq = floor_shift(p, i);
      if (q >= 0) begin
        p += dp; q -= dq;
        ang += longint'(ata_pkg::atan_entry(ata_pkg::STEP_W'(i)));
      end else begin
        p -= dp; q += dq;
        ang -= longint'(ata_pkg::atan_entry(ata_pkg::STEP_W'(i)));
      end
    end
    r = floor_shift(ang + (longint'(1) <<< (15 - FRAC)), 16 - FRAC);
    if (r > full) r = full;
    if (r < -full) r = -full;
    return r;
  endfunction

  function automatic logic [15:0] clip16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic ata_pkg::out_t predict_tilt(ata_pkg::in_t s);
    longint cx, cy, cz;
    ata_pkg::out_t o;
    cx = longint'($signed({s.x_high, s.x_low})) - longint'(off_x);
    cy = longint'($signed({s.y_high, s.y_low})) - longint'(off_y);
    cz = longint'($signed({s.z_high, s.z_low})) - longint'(off_z);
    readings = readings + 32'd1;
    o.roll_angle = clip16(-tilt_deg(cy, vec_magnitude(cx, cz)));
    o.pitch_angle = clip16(tilt_deg(cx, vec_magnitude(cy, cz)));
    o.reading_count = readings;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (angles_due.size() == 0) begin
        report("unexpected word", out_data_o.reading_count, 32'd0);
      end else begin
        ata_pkg::out_t w;
        w = angles_due.pop_front();
        if (out_data_o.roll_angle !== w.roll_angle)
          report("roll", 32'(out_data_o.roll_angle), 32'(w.roll_angle));
        if (out_data_o.pitch_angle !== w.pitch_angle)
          report("pitch", 32'(out_data_o.pitch_angle), 32'(w.pitch_angle));
        if (out_data_o.reading_count !== w.reading_count)
          report("count", out_data_o.reading_count, w.reading_count);
      end
    end
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // valid stays high after the accept; the caller drops it when it pauses
  task automatic send_sample(ata_pkg::in_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    angles_due.push_back(predict_tilt(s));
  endtask

  task automatic send_axes(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    ata_pkg::in_t s;
    s = '{x[7:0], x[15:8], y[7:0], y[15:8], z[7:0], z[15:8]};
    send_sample(s);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (angles_due.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task automatic write_offset(logic [1:0] idx, logic [15:0] v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ata_pkg::PADDR_W'({idx, 2'b00}); pwdata <= {{16{v[15]}}, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      ata_pkg::REG_OFFSET_X: off_x = v;
      ata_pkg::REG_OFFSET_Y: off_y = v;
      ata_pkg::REG_OFFSET_Z: off_z = v;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_offsets(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    write_offset(ata_pkg::REG_OFFSET_X, x);
    write_offset(ata_pkg::REG_OFFSET_Y, y);
    write_offset(ata_pkg::REG_OFFSET_Z, z);
  endtask

  task automatic send_random(int n);
    ata_pkg::in_t s;
    logic [15:0] a[3];
    for (int k = 0; k < n; k++) begin
      for (int j = 0; j < 3; j++)
        case ($urandom_range(5))
          0: a[j] = 16'h0000;
          1: a[j] = 16'($signed($urandom_range(0, 64)) - 32);
          2: a[j] = $urandom_range(1) ? 16'h7fff : 16'h8000;
          default: a[j] = 16'($urandom);
        endcase
      s = '{a[0][7:0], a[0][15:8], a[1][7:0], a[1][15:8], a[2][7:0], a[2][15:8]};
      send_sample(s);
    end
  endtask

  task automatic test_directed();
    send_axes(16'h0000, 16'h0000, 16'h0000);   // all zero
    send_axes(16'h0000, 16'h0000, 16'h4000);   // flat
    send_axes(16'h4000, 16'h0000, 16'h0000);   // zero denominators
    send_axes(16'hc000, 16'h0000, 16'h0000);
    send_axes(16'h0000, 16'h4000, 16'h0000);
    send_axes(16'h0000, 16'hc000, 16'h0000);
    send_axes(16'h7fff, 16'h7fff, 16'h7fff);
    send_axes(16'h8000, 16'h8000, 16'h8000);
    send_axes(16'h7fff, 16'h8000, 16'h0001);
    send_axes(16'h0001, 16'hffff, 16'h7fff);
    send_axes(16'hffff, 16'h0001, 16'h8000);
    send_axes(16'h00ff, 16'hff00, 16'h5555);
    send_axes(16'haaaa, 16'h5555, 16'h0000);
    drain();
  endtask

  task automatic test_offsets();
    // extremes give calibrated values up to +-65535
    set_offsets(16'h8000, 16'h7fff, 16'h8000);
    send_axes(16'h7fff, 16'h8000, 16'h7fff);
    send_axes(16'h8000, 16'h7fff, 16'h8000);
    send_random(10);
    drain();
    // offset equal to sample gives exact zero
    set_offsets(16'h1234, 16'hf00d, 16'h0100);
    send_axes(16'h1234, 16'hf00d, 16'h0100);
    send_axes(16'h1234, 16'h0000, 16'h0100);
    send_random(20);
    drain();
    set_offsets(16'($urandom), 16'($urandom), 16'($urandom));
    send_random(30);
    drain();
    set_offsets(16'h0000, 16'h0000, 16'h0000);
  endtask

  task automatic test_random();
    send_idle_pct = 0;  recv_stall_pct = 0;  send_random(140);
    send_idle_pct = 51; recv_stall_pct = 0;  send_random(130);
    send_idle_pct = 0;  recv_stall_pct = 51; send_random(130);
    send_idle_pct = 32; recv_stall_pct = 32; send_random(130);
    drain();
    send_idle_pct = 0;  recv_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_recv = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_recv = 1'b0;
      end
      begin
        send_random(12);
        drain();
      end
    join
  endtask

  initial begin
    off_x = '0; off_y = '0; off_z = '0; readings = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_offsets();
    test_backpressure();
    test_random();
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
